### hdl/bcis_pkg.sv
package bcis_pkg;
	localparam int MemDepth = 65536;
	localparam int MemAw = $clog2(MemDepth);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_EXEC  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [15:0] PC_RESET = 16'hFFFC;
	localparam logic [7:0]  SP_RESET = 8'hFF;
	localparam logic [7:0]  STACK_PAGE = 8'h01;

	localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
	localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
	localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
	localparam logic [7:0] OPC_LDA_ABS = 8'hAD;
	localparam logic [7:0] OPC_LDX_ABS = 8'hAE;
	localparam logic [7:0] OPC_LDY_ABS = 8'hAC;
	localparam logic [7:0] OPC_LDA_ZP  = 8'hA5;
	localparam logic [7:0] OPC_LDX_ZP  = 8'hA6;
	localparam logic [7:0] OPC_LDY_ZP  = 8'hA4;
	localparam logic [7:0] OPC_STA_ZP  = 8'h85;
	localparam logic [7:0] OPC_STX_ZP  = 8'h86;
	localparam logic [7:0] OPC_STY_ZP  = 8'h84;
	localparam logic [7:0] OPC_STA_ABS = 8'h8D;
	localparam logic [7:0] OPC_STX_ABS = 8'h8E;
	localparam logic [7:0] OPC_STY_ABS = 8'h8C;
	localparam logic [7:0] OPC_JSR     = 8'h20;
	localparam logic [7:0] OPC_RTS     = 8'h60;
	localparam logic [7:0] OPC_JMP     = 8'h4C;
	localparam logic [7:0] OPC_ADD     = 8'h69;
	localparam logic [7:0] OPC_SUB     = 8'hE9;
	localparam logic [7:0] OPC_BEQ     = 8'hF0;
	localparam logic [7:0] OPC_BNE     = 8'hD0;
endpackage

### hdl/bcis_ram.sv
module bcis_ram #(
	parameter int Width = 8,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hdl/byte_cpu_instruction_step.sv
// Small 8-bit processor with a 64 KiB byte memory in one RAM (a write port and a
// registered read port) and a program counter that counts down.
// A write item, a read item (through a read wait state) and an execute item while
// halted go on to delivery; else an execute item steps through one state per
// memory access before the delivering state. After reset a clearing pass zeroes
// the memory, one byte a cycle, before the first item is accepted.
// The result is held in an output register until taken.
module byte_cpu_instruction_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pc,
	output logic [7:0]  acc,
	output logic [7:0]  xreg,
	output logic [7:0]  yreg,
	output logic [7:0]  stack_ptr,
	output logic        zero_flag,
	output logic        halted,
	output logic [7:0]  read_data
);
	localparam int Aw = bcis_pkg::MemAw;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RDWAIT, S_OPC, S_B1, S_B2, S_DATA, S_POPHI, S_POPDONE,
		S_PUSHLO, S_DONE
	} state_t;

	state_t      state_q;
	logic [Aw:0] clr_q;
	logic [15:0] pc_q;
	logic [7:0]  sp_q, a_q, x_q, y_q, opc_q, b1_q;
	logic        z_q, h_q;

	logic          we;
	logic [Aw-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	bcis_ram #(.Width(8), .Depth(bcis_pkg::MemDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [Aw-1:0] mem_addr(input logic [15:0] a);
		mem_addr = a[Aw-1:0];
	endfunction

	function automatic logic [1:0] opc_len(input logic [7:0] o);
		// operand bytes: 0 none, 1 one, 2 two
		unique case (o)
			bcis_pkg::OPC_LDA_IMM, bcis_pkg::OPC_LDX_IMM, bcis_pkg::OPC_LDY_IMM,
			bcis_pkg::OPC_LDA_ZP, bcis_pkg::OPC_LDX_ZP, bcis_pkg::OPC_LDY_ZP,
			bcis_pkg::OPC_STA_ZP, bcis_pkg::OPC_STX_ZP, bcis_pkg::OPC_STY_ZP,
			bcis_pkg::OPC_BEQ, bcis_pkg::OPC_BNE: opc_len = 2'd1;
			bcis_pkg::OPC_LDA_ABS, bcis_pkg::OPC_LDX_ABS, bcis_pkg::OPC_LDY_ABS,
			bcis_pkg::OPC_STA_ABS, bcis_pkg::OPC_STX_ABS, bcis_pkg::OPC_STY_ABS,
			bcis_pkg::OPC_JSR, bcis_pkg::OPC_JMP, bcis_pkg::OPC_ADD,
			bcis_pkg::OPC_SUB: opc_len = 2'd2;
			default: opc_len = 2'd0;
		endcase
	endfunction

	function automatic logic [7:0] store_src(input logic [7:0] o, input logic [7:0] a,
			input logic [7:0] x, input logic [7:0] y);
		unique case (o)
			bcis_pkg::OPC_STX_ZP, bcis_pkg::OPC_STX_ABS: store_src = x;
			bcis_pkg::OPC_STY_ZP, bcis_pkg::OPC_STY_ABS: store_src = y;
			default: store_src = a;
		endcase
	endfunction

	logic [7:0] sp_inc;
	logic [15:0] pc_dec;
	logic in_fire;
	assign sp_inc = sp_q + 8'd1;
	assign pc_dec = pc_q - 16'd1;
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign in_fire = in_valid && in_ready;

	// memory port control for the write port and the read port
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = 8'd0;
		raddr = pc_q[Aw-1:0];
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q[Aw-1:0];
			end
			S_IDLE: begin
				if (in_fire && op == bcis_pkg::OP_WRITE) begin
					we = 1'b1;
					waddr = addr[Aw-1:0];
					wdata = data;
				end
				if (in_fire && op == bcis_pkg::OP_READ) raddr = addr[Aw-1:0];
			end
			S_OPC: begin
				if (rdata == bcis_pkg::OPC_RTS) raddr = mem_addr({bcis_pkg::STACK_PAGE, sp_inc});
				else raddr = mem_addr(pc_dec);
			end
			S_B1: begin
				unique case (opc_q)
					bcis_pkg::OPC_LDA_ZP, bcis_pkg::OPC_LDX_ZP, bcis_pkg::OPC_LDY_ZP:
						raddr = mem_addr({8'h00, rdata});
					bcis_pkg::OPC_STA_ZP, bcis_pkg::OPC_STX_ZP, bcis_pkg::OPC_STY_ZP: begin
						we = 1'b1;
						waddr = mem_addr({8'h00, rdata});
						wdata = store_src(opc_q, a_q, x_q, y_q);
					end
					default: raddr = mem_addr(pc_dec);
				endcase
			end
			S_B2: begin
				unique case (opc_q)
					bcis_pkg::OPC_STA_ABS, bcis_pkg::OPC_STX_ABS,
					bcis_pkg::OPC_STY_ABS: begin
						we = 1'b1;
						waddr = mem_addr({b1_q, rdata});
						wdata = store_src(opc_q, a_q, x_q, y_q);
					end
					bcis_pkg::OPC_JSR: begin
						we = 1'b1;
						waddr = mem_addr({bcis_pkg::STACK_PAGE, sp_q});
						wdata = pc_dec[15:8];
					end
					default: raddr = mem_addr({b1_q, rdata});
				endcase
			end
			S_POPHI: raddr = mem_addr({bcis_pkg::STACK_PAGE, sp_inc});
			S_PUSHLO: begin
				we = 1'b1;
				waddr = mem_addr({bcis_pkg::STACK_PAGE, sp_q});
				wdata = b1_q;
			end
			default: ;
		endcase
	end

	logic [15:0] tgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			pc_q <= bcis_pkg::PC_RESET;
			sp_q <= bcis_pkg::SP_RESET;
			a_q <= 8'd0;
			x_q <= 8'd0;
			y_q <= 8'd0;
			z_q <= 1'b0;
			h_q <= 1'b0;
			out_valid <= 1'b0;
			read_data <= 8'd0;
			opc_q <= 8'd0;
			b1_q <= 8'd0;
			tgt_q <= 16'd0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (Aw+1)'(bcis_pkg::MemDepth - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_fire) begin
						read_data <= 8'd0;
						priority if (op == bcis_pkg::OP_READ) state_q <= S_RDWAIT;
						else if (op == bcis_pkg::OP_EXEC && !h_q) state_q <= S_OPC;
						else state_q <= S_DONE;
					end
				end
				S_RDWAIT: begin
					read_data <= rdata;
					state_q <= S_DONE;
				end
				S_OPC: begin
					opc_q <= rdata;
					if (rdata == bcis_pkg::OPC_RTS) begin
						sp_q <= sp_inc;
						state_q <= S_POPHI;
					end else if (opc_len(rdata) == 2'd0) begin
						h_q <= 1'b1;
						pc_q <= pc_dec;
						state_q <= S_DONE;
					end else begin
						pc_q <= pc_dec;
						state_q <= S_B1;
					end
				end
				S_B1: begin
					b1_q <= rdata;
					unique case (opc_q)
						bcis_pkg::OPC_LDA_IMM: begin
							a_q <= rdata; z_q <= rdata == 8'd0;
							pc_q <= pc_dec; state_q <= S_DONE;
						end
						bcis_pkg::OPC_LDX_IMM: begin
							x_q <= rdata; z_q <= rdata == 8'd0;
							pc_q <= pc_dec; state_q <= S_DONE;
						end
						bcis_pkg::OPC_LDY_IMM: begin
							y_q <= rdata; z_q <= rdata == 8'd0;
							pc_q <= pc_dec; state_q <= S_DONE;
						end
						bcis_pkg::OPC_LDA_ZP, bcis_pkg::OPC_LDX_ZP,
						bcis_pkg::OPC_LDY_ZP: begin
							pc_q <= pc_dec; state_q <= S_DATA;
						end
						bcis_pkg::OPC_BEQ, bcis_pkg::OPC_BNE: begin
							state_q <= S_DONE;
							if ((opc_q == bcis_pkg::OPC_BEQ) == z_q)
								pc_q <= pc_dec + {{8{rdata[7]}}, rdata};
							else
								pc_q <= pc_dec;
						end
						bcis_pkg::OPC_STA_ZP, bcis_pkg::OPC_STX_ZP,
						bcis_pkg::OPC_STY_ZP: begin
							pc_q <= pc_dec; state_q <= S_DONE;
						end
						default: begin
							pc_q <= pc_dec; state_q <= S_B2;
						end
					endcase
				end
				S_B2: begin
					unique case (opc_q)
						bcis_pkg::OPC_JMP: begin
							pc_q <= {b1_q, rdata};
							state_q <= S_DONE;
						end
						bcis_pkg::OPC_JSR: begin
							// hold the return low byte, push it next cycle
							b1_q <= pc_dec[7:0];
							tgt_q <= {b1_q, rdata};
							sp_q <= sp_q - 8'd1;
							state_q <= S_PUSHLO;
						end
						bcis_pkg::OPC_STA_ABS, bcis_pkg::OPC_STX_ABS,
						bcis_pkg::OPC_STY_ABS: begin
							pc_q <= pc_q - 16'd2;
							state_q <= S_DONE;
						end
						default: begin
							pc_q <= pc_q - 16'd2;
							state_q <= S_DATA;
						end
					endcase
				end
				S_DATA: begin
					state_q <= S_DONE;
					unique case (opc_q)
						bcis_pkg::OPC_ADD: a_q <= a_q + rdata;
						bcis_pkg::OPC_SUB: a_q <= a_q - rdata;
						bcis_pkg::OPC_LDX_ABS, bcis_pkg::OPC_LDX_ZP: begin
							x_q <= rdata; z_q <= rdata == 8'd0;
						end
						bcis_pkg::OPC_LDY_ABS, bcis_pkg::OPC_LDY_ZP: begin
							y_q <= rdata; z_q <= rdata == 8'd0;
						end
						default: begin a_q <= rdata; z_q <= rdata == 8'd0; end
					endcase
				end
				S_POPHI: begin
					b1_q <= rdata;
					sp_q <= sp_inc;
					state_q <= S_POPDONE;
				end
				S_POPDONE: begin
					pc_q <= {rdata, b1_q};
					state_q <= S_DONE;
				end
				S_PUSHLO: begin
					sp_q <= sp_q - 8'd1;
					pc_q <= tgt_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pc = pc_q;
	assign acc = a_q;
	assign xreg = x_q;
	assign yreg = y_q;
	assign stack_ptr = sp_q;
	assign zero_flag = z_q;
	assign halted = h_q;

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE && !out_valid)
		else $error("accept outside idle");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		h_q |=> h_q) else $error("halt cleared");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_valid) else $error("result lost");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		$past(h_q) && state_q != S_CLEAR |-> $stable(pc_q)) else $error("pc moved halted");
`endif
endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int NUM_ITEMS = 1650;

	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  acc;
		logic [7:0]  xreg;
		logic [7:0]  yreg;
		logic [7:0]  sp;
		logic        zf;
		logic        hlt;
		logic [7:0]  rd;
	} cpu_view_t;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] addr;
		logic [7:0]  data;
		bit          typed;
		cpu_view_t   view;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [15:0] addr;
	logic [7:0]  data;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] pc;
	logic [7:0]  acc;
	logic [7:0]  xreg;
	logic [7:0]  yreg;
	logic [7:0]  stack_ptr;
	logic        zero_flag;
	logic        halted;
	logic [7:0]  read_data;

	// shadow of the processor state
	logic [7:0]  mem_img [0:bcis_pkg::MemDepth-1];
	logic [15:0] pc_m;
	logic [7:0]  acc_m, x_m, y_m, sp_m;
	logic        z_m, halt_m;

	cpu_view_t   expected_q[$];
	int          err_cnt;
	int          item_cnt;
	bit          quiet;
	logic [7:0]  opc_list [22];

	byte_cpu_instruction_step u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .addr(addr), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.pc(pc), .acc(acc), .xreg(xreg), .yreg(yreg), .stack_ptr(stack_ptr),
		.zero_flag(zero_flag), .halted(halted), .read_data(read_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] fetch_byte();
		logic [7:0] v;
		v = mem_img[pc_m];
		pc_m = pc_m - 16'd1;
		return v;
	endfunction

	function automatic logic [15:0] fetch_word();
		logic [7:0] hi, lo;
		hi = fetch_byte();
		lo = fetch_byte();
		return {hi, lo};
	endfunction

	function automatic logic [7:0] load_flag(logic [7:0] v);
		z_m = (v == 8'd0);
		return v;
	endfunction

	function automatic void run_instr();
		logic [7:0]  opc, off, lo, hi;
		logic [15:0] a;
		opc = fetch_byte();
		case (opc)
			bcis_pkg::OPC_LDA_IMM: acc_m = load_flag(fetch_byte());
			bcis_pkg::OPC_LDX_IMM: x_m = load_flag(fetch_byte());
			bcis_pkg::OPC_LDY_IMM: y_m = load_flag(fetch_byte());
			bcis_pkg::OPC_LDA_ZP:  acc_m = load_flag(mem_img[{8'd0, fetch_byte()}]);
			bcis_pkg::OPC_LDX_ZP:  x_m = load_flag(mem_img[{8'd0, fetch_byte()}]);
			bcis_pkg::OPC_LDY_ZP:  y_m = load_flag(mem_img[{8'd0, fetch_byte()}]);
			bcis_pkg::OPC_STA_ZP:  mem_img[{8'd0, fetch_byte()}] = acc_m;
			bcis_pkg::OPC_STX_ZP:  mem_img[{8'd0, fetch_byte()}] = x_m;
			bcis_pkg::OPC_STY_ZP:  mem_img[{8'd0, fetch_byte()}] = y_m;
			bcis_pkg::OPC_LDA_ABS, bcis_pkg::OPC_LDX_ABS, bcis_pkg::OPC_LDY_ABS,
			bcis_pkg::OPC_STA_ABS, bcis_pkg::OPC_STX_ABS, bcis_pkg::OPC_STY_ABS,
			bcis_pkg::OPC_ADD, bcis_pkg::OPC_SUB: begin
				a = fetch_word();
				pc_m = pc_m - 16'd1;
				case (opc)
					bcis_pkg::OPC_LDA_ABS: acc_m = load_flag(mem_img[a]);
					bcis_pkg::OPC_LDX_ABS: x_m = load_flag(mem_img[a]);
					bcis_pkg::OPC_LDY_ABS: y_m = load_flag(mem_img[a]);
					bcis_pkg::OPC_STA_ABS: mem_img[a] = acc_m;
					bcis_pkg::OPC_STX_ABS: mem_img[a] = x_m;
					bcis_pkg::OPC_STY_ABS: mem_img[a] = y_m;
					bcis_pkg::OPC_ADD:     acc_m = acc_m + mem_img[a];
					default:               acc_m = acc_m - mem_img[a];
				endcase
			end
			bcis_pkg::OPC_JSR: begin
				a = fetch_word();
				mem_img[{bcis_pkg::STACK_PAGE, sp_m}] = pc_m[15:8];
				sp_m = sp_m - 8'd1;
				mem_img[{bcis_pkg::STACK_PAGE, sp_m}] = pc_m[7:0];
				sp_m = sp_m - 8'd1;
				pc_m = a;
			end
			bcis_pkg::OPC_RTS: begin
				sp_m = sp_m + 8'd1;
				lo = mem_img[{bcis_pkg::STACK_PAGE, sp_m}];
				sp_m = sp_m + 8'd1;
				hi = mem_img[{bcis_pkg::STACK_PAGE, sp_m}];
				pc_m = {hi, lo};
			end
			bcis_pkg::OPC_JMP: pc_m = fetch_word();
			bcis_pkg::OPC_BEQ, bcis_pkg::OPC_BNE: begin
				off = fetch_byte();
				if (z_m == (opc == bcis_pkg::OPC_BEQ))
					pc_m = pc_m + {{8{off[7]}}, off};
			end
			default: halt_m = 1'b1;
		endcase
	endfunction

	function automatic cpu_view_t cpu_predict(logic [1:0] o, logic [15:0] a, logic [7:0] d);
		cpu_view_t v;
		v.rd = 8'd0;
		case (o)
			bcis_pkg::OP_WRITE: mem_img[a] = d;
			bcis_pkg::OP_EXEC:  if (!halt_m) run_instr();
			bcis_pkg::OP_READ:  v.rd = mem_img[a];
			default: ;
		endcase
		v.pc = pc_m;
		v.acc = acc_m;
		v.xreg = x_m;
		v.yreg = y_m;
		v.sp = sp_m;
		v.zf = z_m;
		v.hlt = halt_m;
		return v;
	endfunction

	task automatic report(string field, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
		err_cnt++;
	endtask

	// drive one transaction; the expectation is queued at the accepting edge
	task automatic send(logic [1:0] o, logic [15:0] a, logic [7:0] d,
			bit typed = 1'b0, cpu_view_t tv = '0);
		int gap;
		cpu_view_t v;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op <= o;
		addr <= a;
		data <= d;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		v = cpu_predict(o, a, d);
		expected_q.push_back(typed ? tv : v);
		item_cnt++;
		quiet = ((item_cnt / 120) % 5) == 4;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 4))
			0: return {8'd0, 8'($urandom)};
			1: return {bcis_pkg::STACK_PAGE, 8'($urandom)};
			2: return pc_m - 16'($urandom_range(4, 40));
			3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	// lays down one well-formed instruction at the current pc and runs it
	task automatic random_instr();
		logic [7:0]  opc;
		logic [7:0]  prog [4];
		logic [15:0] a, base;
		int n;
		opc = opc_list[$urandom_range(0, 21)];
		a = pick_addr();
		n = 2;
		prog[0] = opc;
		prog[1] = pick_byte();
		case (opc)
			bcis_pkg::OPC_RTS: n = 1;
			bcis_pkg::OPC_LDA_ZP, bcis_pkg::OPC_LDX_ZP, bcis_pkg::OPC_LDY_ZP: begin
				if ($urandom_range(0, 1))
					send(bcis_pkg::OP_WRITE, {8'd0, prog[1]}, pick_byte());
			end
			bcis_pkg::OPC_LDA_ABS, bcis_pkg::OPC_LDX_ABS, bcis_pkg::OPC_LDY_ABS,
			bcis_pkg::OPC_STA_ABS, bcis_pkg::OPC_STX_ABS, bcis_pkg::OPC_STY_ABS,
			bcis_pkg::OPC_ADD, bcis_pkg::OPC_SUB, bcis_pkg::OPC_JSR,
			bcis_pkg::OPC_JMP: begin
				if (opc != bcis_pkg::OPC_JSR && opc != bcis_pkg::OPC_JMP) begin
					n = 4;
					if ($urandom_range(0, 1)) send(bcis_pkg::OP_WRITE, a, pick_byte());
				end else
					n = 3;
				prog[1] = a[15:8];
				prog[2] = a[7:0];
				prog[3] = 8'($urandom);
			end
			default: ;
		endcase
		base = pc_m;
		for (int i = 0; i < n; i++)
			if (i < 3 || $urandom_range(0, 1))
				send(bcis_pkg::OP_WRITE, base - 16'(i), prog[i]);
		send(bcis_pkg::OP_EXEC, 16'($urandom), 8'($urandom));
		if ($urandom_range(0, 3) == 0) send(bcis_pkg::OP_READ, a, 8'($urandom));
	endtask

	always @(posedge clk) begin
		cpu_view_t w;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				err_cnt++;
			end else begin
				w = expected_q.pop_front();
				if (pc !== w.pc) report("pc", pc, w.pc);
				if (acc !== w.acc) report("acc", 16'(acc), 16'(w.acc));
				if (xreg !== w.xreg) report("xreg", 16'(xreg), 16'(w.xreg));
				if (yreg !== w.yreg) report("yreg", 16'(yreg), 16'(w.yreg));
				if (stack_ptr !== w.sp) report("stack_ptr", 16'(stack_ptr), 16'(w.sp));
				if (zero_flag !== w.zf) report("zero_flag", 16'(zero_flag), 16'(w.zf));
				if (halted !== w.hlt) report("halted", 16'(halted), 16'(w.hlt));
				if (read_data !== w.rd) report("read_data", 16'(read_data), 16'(w.rd));
			end
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = quiet ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		stim_row_t rows[$];
		cpu_view_t rst_view;
		err_cnt = 0;
		item_cnt = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = bcis_pkg::OP_WRITE;
		addr = '0;
		data = '0;
		opc_list = '{bcis_pkg::OPC_LDA_IMM, bcis_pkg::OPC_LDX_IMM, bcis_pkg::OPC_LDY_IMM,
			bcis_pkg::OPC_LDA_ABS, bcis_pkg::OPC_LDX_ABS, bcis_pkg::OPC_LDY_ABS,
			bcis_pkg::OPC_LDA_ZP, bcis_pkg::OPC_LDX_ZP, bcis_pkg::OPC_LDY_ZP,
			bcis_pkg::OPC_STA_ZP, bcis_pkg::OPC_STX_ZP, bcis_pkg::OPC_STY_ZP,
			bcis_pkg::OPC_STA_ABS, bcis_pkg::OPC_STX_ABS, bcis_pkg::OPC_STY_ABS,
			bcis_pkg::OPC_JSR, bcis_pkg::OPC_RTS, bcis_pkg::OPC_JMP,
			bcis_pkg::OPC_ADD, bcis_pkg::OPC_SUB, bcis_pkg::OPC_BEQ, bcis_pkg::OPC_BNE};
		for (int i = 0; i < bcis_pkg::MemDepth; i++) mem_img[i] = 8'd0;
		pc_m = bcis_pkg::PC_RESET;
		sp_m = bcis_pkg::SP_RESET;
		acc_m = 8'd0;
		x_m = 8'd0;
		y_m = 8'd0;
		z_m = 1'b0;
		halt_m = 1'b0;

		rst_view = '{pc: bcis_pkg::PC_RESET, acc: 8'd0, xreg: 8'd0, yreg: 8'd0,
			sp: bcis_pkg::SP_RESET, zf: 1'b0, hlt: 1'b0, rd: 8'd0};
		rows.push_back('{bcis_pkg::OP_READ, 16'h0000, 8'h00, 1'b1, rst_view});
		rows.push_back('{bcis_pkg::OP_READ, 16'hFFFF, 8'hFF, 1'b1, rst_view});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFFC, bcis_pkg::OPC_LDA_IMM, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFFB, 8'h00, 1'b0, '0});
		// load of zero sets the flag
		rows.push_back('{bcis_pkg::OP_EXEC, 16'h0000, 8'h00, 1'b1, '{16'hFFFA, 8'h00,
			8'h00, 8'h00, bcis_pkg::SP_RESET, 1'b1, 1'b0, 8'h00}});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFFA, bcis_pkg::OPC_LDX_IMM, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF9, 8'hFF, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_EXEC, 16'hFFFF, 8'hFF, 1'b1, '{16'hFFF8, 8'h00,
			8'hFF, 8'h00, bcis_pkg::SP_RESET, 1'b0, 1'b0, 8'h00}});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF8, bcis_pkg::OPC_STX_ABS, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF7, 8'hFF, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF6, 8'hFF, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_READ, 16'hFFFF, 8'h00, 1'b0, '0});
		// subroutine call and return
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF4, bcis_pkg::OPC_JSR, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF3, 8'h00, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF2, 8'h40, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'h0040, bcis_pkg::OPC_RTS, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
		// taken branch, most negative offset
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF1, bcis_pkg::OPC_BNE, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFF0, 8'h80, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFF6F, bcis_pkg::OPC_JMP, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFF6E, 8'h00, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFF6D, 8'h00, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
		// pc wraps below zero, branch not taken
		rows.push_back('{bcis_pkg::OP_WRITE, 16'h0000, bcis_pkg::OPC_BEQ, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_WRITE, 16'hFFFF, 8'h7F, 1'b0, '0});
		rows.push_back('{bcis_pkg::OP_EXEC, 16'h0000, 8'h00, 1'b0, '0});
		rows.push_back('{OP_NONE, 16'hFFFF, 8'hFF, 1'b0, '0});

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send(rows[i].op, rows[i].addr, rows[i].data, rows[i].typed, rows[i].view);

		while (item_cnt < NUM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0: send(OP_NONE, 16'($urandom), 8'($urandom));
					1: send(bcis_pkg::OP_WRITE, pick_addr(), pick_byte());
					default: send(bcis_pkg::OP_READ, pick_addr(), 8'($urandom));
				endcase
			end else
				random_instr();
			if (item_cnt > NUM_ITEMS / 2 && item_cnt < NUM_ITEMS / 2 + 8) begin
				in_valid <= 1'b0;
				while (expected_q.size() != 0) @(negedge clk);
			end
		end

		// unknown opcode halts; memory access keeps working afterwards
		send(bcis_pkg::OP_WRITE, pc_m, 8'h02);
		send(bcis_pkg::OP_EXEC, 16'h0000, 8'h00);
		send(bcis_pkg::OP_WRITE, pc_m, bcis_pkg::OPC_LDA_IMM);
		send(bcis_pkg::OP_EXEC, 16'hFFFF, 8'hFF);
		send(bcis_pkg::OP_WRITE, 16'h1234, 8'hA5);
		send(bcis_pkg::OP_READ, 16'h1234, 8'h00);
		send(OP_NONE, 16'h0000, 8'h00);
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### files.f
hdl/bcis_pkg.sv
hdl/bcis_ram.sv
hdl/byte_cpu_instruction_step.sv
sim/tb_top.sv
